### hw/rtl/ism_pkg.sv
// ----------------------------------------------------------------------------
// ism_pkg: shared definitions of the interval subscription matcher
// Sizes, command codes, sequencer states and the walk control group.
// ----------------------------------------------------------------------------
package ism_pkg;

    localparam int SUBS        = 1024;
    localparam int ATTRIBUTES  = 16;
    localparam int SUB_W       = $clog2(SUBS);
    localparam int ATT_W       = 4;
    localparam int VAL_W       = 20;
    localparam int CNT_W       = 11;
    localparam int ROW_W       = ATTRIBUTES + 1;
    localparam int BND_W       = 2 * VAL_W;
    localparam int STORE_DEPTH = SUBS * ATTRIBUTES;
    localparam int IN_DATA_W   = 80;
    localparam int OUT_DATA_W  = 16;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_EVENT  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INS_READ,
        ST_INS_WRITE,
        ST_WALK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                  final_walk;
        logic [ATT_W-1:0]      att;
        logic [ATTRIBUTES-1:0] seen;
    } walk_ctrl_t;

endpackage

### hw/rtl/ism_ram.sv
// ----------------------------------------------------------------------------
// ism_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ism_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/ism_eval.sv
// ----------------------------------------------------------------------------
// ism_eval: per-subscription verdict of one table walk step
// Compares the stored interval with the event value and folds in the
// attributes that the finished event never named.
// ----------------------------------------------------------------------------
module ism_eval
    import ism_pkg::*;
(
    input  walk_ctrl_t       ctrl,
    input  logic [ROW_W-1:0] row,
    input  logic [BND_W-1:0] bounds,
    input  logic [VAL_W-1:0] value,
    output logic [ROW_W-1:0] new_row,
    output logic             unmatched
);

    logic [ATTRIBUTES-1:0] present;
    logic [VAL_W-1:0]      low;
    logic [VAL_W-1:0]      high;
    logic                  excluded;
    logic                  missing;

    always_comb
    begin
        present   = row[ATTRIBUTES-1:0];
        low       = bounds[VAL_W-1:0];
        high      = bounds[BND_W-1:VAL_W];
        excluded  = present[ctrl.att] && ((low > value) || (high < value));
        missing   = ctrl.final_walk && (|(present & ~ctrl.seen));
        unmatched = row[ATTRIBUTES] | excluded | missing;
        new_row   = {(ctrl.final_walk ? 1'b0 : unmatched), present};
    end

endmodule

### hw/rtl/interval_subscription_matcher_unit.sv
// ----------------------------------------------------------------------------
// interval_subscription_matcher_unit: content-based interval matcher
// Stores interval constraints per subscription and attribute and counts
// the subscriptions that a run of attribute/value pairs matches.
//
//   Channel  Dir  Signals                      Content
//   s        in   s_tvalid s_tready s_tdata    insert or event pair word
//                 s_tuser s_tlast              (tuser = cmd, tlast = last_pair)
//   m        out  m_tvalid m_tready m_tdata    match count word
//
// An insert writes the bounds and reads the row in ST_INS_READ and writes
// the row back in ST_INS_WRITE. An event pair walks the subscription row
// memory, one row per cycle, and the last pair of an event then passes ST_FINISH.
// After reset the row memory is cleared in a pass over all SUBS rows with
// s_tready low. A finished count waits in the output register; a last pair
// that completes while that register is still full holds until it drains.
// ----------------------------------------------------------------------------
module interval_subscription_matcher_unit
    import ism_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Fields from bit 0: sub_id[9:0], attribute[13:10], low_bound[33:14],
    // high_bound[53:34], event_value[73:54], zero fill [79:74].
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // Fields from bit 0: cmd.
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // Fields from bit 0: match_count[10:0], zero fill [15:11].
    output logic [OUT_DATA_W-1:0] m_tdata
);

    state_t                state_reg, state_next;
    logic [SUB_W-1:0]      cnt_reg, cnt_next;
    logic                  issue_done_reg, issue_done_next;
    logic                  pipe_valid_reg, pipe_valid_next;
    logic [SUB_W-1:0]      pipe_idx_reg;
    logic [ATTRIBUTES-1:0] seen_reg, seen_next;
    logic [CNT_W-1:0]      unm_cnt_reg, unm_cnt_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [CNT_W-1:0]      match_reg;
    logic                  load_out;

    logic [SUB_W-1:0]      sub_reg;
    logic [ATT_W-1:0]      att_reg;
    logic [VAL_W-1:0]      lo_reg;
    logic [VAL_W-1:0]      hi_reg;
    logic [VAL_W-1:0]      val_reg;
    logic                  last_reg;

    logic                  accept;
    logic [ATTRIBUTES-1:0] att_onehot;
    walk_ctrl_t            walk_ctrl;

    logic                  row_we;
    logic [SUB_W-1:0]      row_waddr;
    logic [ROW_W-1:0]      row_wdata;
    logic [SUB_W-1:0]      row_raddr;
    logic [ROW_W-1:0]      row_rdata;
    logic                  bnd_we;
    logic [BND_W-1:0]      bnd_rdata;
    logic [ROW_W-1:0]      eval_row;
    logic                  eval_unm;

    assign accept     = s_tvalid && s_tready;
    assign att_onehot = ATTRIBUTES'(1) << att_reg;

    assign walk_ctrl.final_walk = last_reg;
    assign walk_ctrl.att        = att_reg;
    assign walk_ctrl.seen       = seen_reg | att_onehot;

    ism_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SUBS)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    ism_ram #(
        .WIDTH (BND_W),
        .DEPTH (STORE_DEPTH)
    ) u_bnd_ram (
        .clk   (clk),
        .we    (bnd_we),
        .waddr ({sub_reg, att_reg}),
        .wdata ({hi_reg, lo_reg}),
        .raddr ({cnt_reg, att_reg}),
        .rdata (bnd_rdata)
    );

    ism_eval u_eval (
        .ctrl      (walk_ctrl),
        .row       (row_rdata),
        .bounds    (bnd_rdata),
        .value     (val_reg),
        .new_row   (eval_row),
        .unmatched (eval_unm)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            issue_done_reg <= 1'b0;
            pipe_valid_reg <= 1'b0;
            seen_reg       <= '0;
            unm_cnt_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            issue_done_reg <= issue_done_next;
            pipe_valid_reg <= pipe_valid_next;
            seen_reg       <= seen_next;
            unm_cnt_reg    <= unm_cnt_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_idx_reg <= cnt_reg;
        if (accept)
        begin
            sub_reg  <= s_tdata[9:0];
            att_reg  <= s_tdata[13:10];
            lo_reg   <= s_tdata[33:14];
            hi_reg   <= s_tdata[53:34];
            val_reg  <= s_tdata[73:54];
            last_reg <= (s_tuser == CMD_EVENT) && s_tlast;
        end
        if (load_out)
        begin
            match_reg <= CNT_W'(SUBS) - unm_cnt_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        issue_done_next = issue_done_reg;
        pipe_valid_next = 1'b0;
        seen_next       = seen_reg;
        unm_cnt_next    = unm_cnt_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        load_out        = 1'b0;
        s_tready        = 1'b0;
        row_we          = 1'b0;
        row_waddr       = cnt_reg;
        row_wdata       = '0;
        row_raddr       = cnt_reg;
        bnd_we          = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                row_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SUB_W'(SUBS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser == CMD_INSERT)
                    begin
                        state_next = ST_INS_READ;
                    end
                    else
                    begin
                        state_next      = ST_WALK;
                        cnt_next        = '0;
                        issue_done_next = 1'b0;
                        unm_cnt_next    = '0;
                    end
                end
            end
            ST_INS_READ:
            begin
                row_raddr  = sub_reg;
                bnd_we     = 1'b1;
                state_next = ST_INS_WRITE;
            end
            ST_INS_WRITE:
            begin
                row_we     = 1'b1;
                row_waddr  = sub_reg;
                row_wdata  = row_rdata | {1'b0, att_onehot};
                state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                if (!issue_done_reg)
                begin
                    pipe_valid_next = 1'b1;
                    cnt_next        = cnt_reg + 1'b1;
                    if (cnt_reg == SUB_W'(SUBS - 1))
                    begin
                        issue_done_next = 1'b1;
                    end
                end
                if (pipe_valid_reg)
                begin
                    row_we    = 1'b1;
                    row_waddr = pipe_idx_reg;
                    row_wdata = eval_row;
                    if (last_reg && eval_unm)
                    begin
                        unm_cnt_next = unm_cnt_reg + 1'b1;
                    end
                end
                if (issue_done_reg && !pipe_valid_reg)
                begin
                    if (last_reg)
                    begin
                        seen_next  = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        seen_next  = seen_reg | att_onehot;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W - CNT_W){1'b0}}, match_reg};

endmodule
